[hdl/amra_pkg.sv]
// Shared types and constants for the magnitude range activity detector.
`timescale 1ns / 1ps

package amra_pkg;

   localparam int FIELD_BITS    = 16;
   localparam int RANGE_BITS    = 16;
   localparam int DUTY_BITS     = 16;
   localparam int THRESH_BITS   = 16;
   localparam int WLEN_BITS     = 12;
   localparam int MODE_BITS     = 2;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUTY_STILL  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUTY_MOVING = 2'd3;

   localparam logic [MODE_BITS-1:0] MODE_IDLE   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_STILL  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MOVING = 2'd2;

   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET   = 16'd10000;
   localparam logic [WLEN_BITS-1:0]   WINDOW_RESET      = 12'd200;
   localparam logic [DUTY_BITS-1:0]   DUTY_STILL_RESET  = 16'd2999;
   localparam logic [DUTY_BITS-1:0]   DUTY_MOVING_RESET = 16'd5999;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] accel_x;
      logic signed [FIELD_BITS-1:0] accel_y;
      logic signed [FIELD_BITS-1:0] accel_z;
      logic                         active;
   } req_type;

   typedef struct packed {
      logic                  window_done;
      logic [RANGE_BITS-1:0] range;
      logic [MODE_BITS-1:0]  activity;
      logic [DUTY_BITS-1:0]  duty;
   } rsp_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0] motion_threshold;
      logic [WLEN_BITS-1:0]   window_length;
      logic [DUTY_BITS-1:0]   duty_still;
      logic [DUTY_BITS-1:0]   duty_moving;
   } cfg_type;

   typedef struct packed {
      logic update;
      logic active;
   } win_ctl_type;

endpackage

[hdl/amra_sqsum.sv]
// Bit-serial sum of squares of the three sample magnitudes.
`timescale 1ns / 1ps

module amra_sqsum #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  amra_pkg::req_type        req,
   output logic                     done,
   output logic [2*SAMPLE_BITS-1:0] sum
);
   import amra_pkg::*;

   localparam int N        = SAMPLE_BITS;
   localparam int CNT_BITS = $clog2(N);

   logic [N-1:0]        raw_x, raw_y, raw_z;
   logic [N-1:0]        abs_x, abs_y, abs_z;
   logic [N-1:0]        ax_ff, ay_ff, az_ff;
   logic [N-1:0]        mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic [N+1:0]        hi_ff, hi_in;
   logic [N-1:0]        lo_ff, lo_in;
   logic [N+1:0]        addend, partial;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   always_comb begin
      raw_x = req.accel_x[N-1:0];
      raw_y = req.accel_y[N-1:0];
      raw_z = req.accel_z[N-1:0];
      abs_x = raw_x[N-1] ? (~raw_x + 1'b1) : raw_x;
      abs_y = raw_y[N-1] ? (~raw_y + 1'b1) : raw_y;
      abs_z = raw_z[N-1] ? (~raw_z + 1'b1) : raw_z;
   end

   always_comb begin
      addend  = (mx_ff[0] ? (N+2)'(ax_ff) : '0)
              + (my_ff[0] ? (N+2)'(ay_ff) : '0)
              + (mz_ff[0] ? (N+2)'(az_ff) : '0);
      partial = hi_ff + addend;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      mz_in   = mz_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         hi_in   = '0;
         lo_in   = '0;
         mx_in   = abs_x;
         my_in   = abs_y;
         mz_in   = abs_z;
         cnt_in  = CNT_BITS'(N-1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = {1'b0, partial[N+1:1]};
         lo_in  = {partial[0], lo_ff[N-1:1]};
         mx_in  = {1'b0, mx_ff[N-1:1]};
         my_in  = {1'b0, my_ff[N-1:1]};
         mz_in  = {1'b0, mz_ff[N-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ax_ff <= abs_x;
         ay_ff <= abs_y;
         az_ff <= abs_z;
      end
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      mz_ff  <= mz_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign sum  = {hi_ff[N-1:0], lo_ff};

endmodule

[hdl/amra_isqrt.sv]
// Digit-serial floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module amra_isqrt #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2*SAMPLE_BITS-1:0] value,
   output logic                     done,
   output logic [SAMPLE_BITS-1:0]   root
);
   import amra_pkg::*;

   localparam int N        = SAMPLE_BITS;
   localparam int CNT_BITS = $clog2(N);

   logic [2*N-1:0]      n_ff, n_in;
   logic [N+1:0]        r_ff, r_in;
   logic [N-1:0]        q_ff, q_in;
   logic [N+1:0]        r_shift, trial;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   always_comb begin
      r_shift = {r_ff[N-1:0], n_ff[2*N-1:2*N-2]};
      trial   = {q_ff, 2'b01};
      n_in    = n_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = value;
         r_in    = '0;
         q_in    = '0;
         cnt_in  = CNT_BITS'(N-1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in   = {n_ff[2*N-3:0], 2'b00};
         cnt_in = cnt_ff - 1'b1;
         if (r_shift >= trial) begin
            r_in = r_shift - trial;
            q_in = {q_ff[N-2:0], 1'b1};
         end else begin
            r_in = r_shift;
            q_in = {q_ff[N-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = q_ff;

endmodule

[hdl/amra_window.sv]
// Window peak/floor tracking, range and mode update, result fields.
`timescale 1ns / 1ps

module amra_window #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  amra_pkg::win_ctl_type  ctl,
   input  logic [SAMPLE_BITS-1:0] mag,
   input  amra_pkg::cfg_type      cfg,
   output amra_pkg::rsp_type      rsp
);
   import amra_pkg::*;

   localparam int N = SAMPLE_BITS;

   logic [WLEN_BITS-1:0] count_ff, count_in;
   logic [N-1:0]         peak_ff, peak_in;
   logic [N-1:0]         floor_ff, floor_in;
   logic [N-1:0]         range_ff, range_in;
   logic [MODE_BITS-1:0] mode_ff, mode_in;
   logic [N-1:0]         peak_nx, floor_nx, diff;
   logic [WLEN_BITS-1:0] count_nx;
   logic [RANGE_BITS-1:0] diff_ext;
   logic                 close;

   always_comb begin
      peak_nx  = (mag >= peak_ff) ? mag : peak_ff;
      floor_nx = (mag <= floor_ff) ? mag : floor_ff;
      count_nx = count_ff + 1'b1;
      close    = (count_nx >= cfg.window_length);
      diff     = peak_nx - floor_nx;
      diff_ext = RANGE_BITS'(diff);

      count_in = count_ff;
      peak_in  = peak_ff;
      floor_in = floor_ff;
      range_in = range_ff;
      mode_in  = mode_ff;
      if (!ctl.active) begin
         count_in = '0;
         peak_in  = '0;
         floor_in = '1;
         range_in = '0;
         mode_in  = MODE_IDLE;
      end else if (close) begin
         count_in = '0;
         peak_in  = '0;
         floor_in = '1;
         range_in = diff;
         if (diff_ext < cfg.motion_threshold) begin
            mode_in = MODE_STILL;
         end else if (diff_ext > cfg.motion_threshold && mode_ff != MODE_IDLE) begin
            mode_in = MODE_MOVING;
         end
      end else begin
         count_in = count_nx;
         peak_in  = peak_nx;
         floor_in = floor_nx;
      end

      rsp.window_done = ctl.active & close;
      rsp.range       = RANGE_BITS'(range_in);
      rsp.activity    = mode_in;
      case (mode_in)
         MODE_STILL:  rsp.duty = cfg.duty_still;
         MODE_MOVING: rsp.duty = cfg.duty_moving;
         default:     rsp.duty = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         peak_ff  <= '0;
         floor_ff <= '1;
         range_ff <= '0;
         mode_ff  <= MODE_IDLE;
      end else if (ctl.update) begin
         count_ff <= count_in;
         peak_ff  <= peak_in;
         floor_ff <= floor_in;
         range_ff <= range_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

[hdl/accel_magnitude_range_activity_top.sv]
// Top level: sequencer, register port and result register.
//
//   channel | direction | handshake                | payload
//   req_    | in        | req_valid / req_stall    | req_data (req_type)
//   rsp_    | out       | rsp_valid / rsp_stall    | rsp_data (rsp_type)
//   csr_    | in/out    | APB, csr_pready tied high| csr_pwdata / csr_prdata
//
// An active sample runs SAMPLE_BITS steps of the serial square summer, then
// SAMPLE_BITS steps of the serial root, then the final state, before the next
// accept. An inactive sample goes from accept straight to the final state.
// Synchronous reset restores register defaults and the idle window state.
// A stalled result holds in the output register; the next sample is still
// taken and waits in the final state until the result register frees.
`timescale 1ns / 1ps

module accel_magnitude_range_activity_top #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  amra_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output amra_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [amra_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [amra_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [amra_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import amra_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SQ   = 2'd1;
   localparam logic [1:0] ST_ROOT = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic                     active_ff, active_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_next;
   cfg_type                  cfg_ff, cfg_in;
   win_ctl_type              win_ctl;
   logic                     req_acc, sq_start, sq_done, rt_start, rt_done;
   logic                     fin_load, slot_free, csr_write;
   logic [CSR_IDX_BITS-1:0]  csr_idx;
   logic [2*SAMPLE_BITS-1:0] sq_sum;
   logic [SAMPLE_BITS-1:0]   mag;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign sq_start  = req_acc && req_data.active;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      rt_start  = 1'b0;
      fin_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               active_in = req_data.active;
               state_in  = req_data.active ? ST_SQ : ST_FIN;
            end
         end
         ST_SQ: begin
            if (sq_done) begin
               rt_start = 1'b1;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rt_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               fin_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign win_ctl.update = fin_load;
   assign win_ctl.active = active_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx)
            CSR_THRESHOLD:   cfg_in.motion_threshold = csr_pwdata[THRESH_BITS-1:0];
            CSR_WINDOW:      cfg_in.window_length    = csr_pwdata[WLEN_BITS-1:0];
            CSR_DUTY_STILL:  cfg_in.duty_still       = csr_pwdata[DUTY_BITS-1:0];
            CSR_DUTY_MOVING: cfg_in.duty_moving      = csr_pwdata[DUTY_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_THRESHOLD:   csr_prdata = CSR_DATA_BITS'(cfg_ff.motion_threshold);
         CSR_WINDOW:      csr_prdata = CSR_DATA_BITS'(cfg_ff.window_length);
         CSR_DUTY_STILL:  csr_prdata = CSR_DATA_BITS'(cfg_ff.duty_still);
         CSR_DUTY_MOVING: csr_prdata = CSR_DATA_BITS'(cfg_ff.duty_moving);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= ST_IDLE;
         active_ff               <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         cfg_ff.motion_threshold <= THRESHOLD_RESET;
         cfg_ff.window_length    <= WINDOW_RESET;
         cfg_ff.duty_still       <= DUTY_STILL_RESET;
         cfg_ff.duty_moving      <= DUTY_MOVING_RESET;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) rsp_ff <= rsp_next;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   amra_sqsum #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_sqsum (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .req   (req_data),
      .done  (sq_done),
      .sum   (sq_sum)
   );

   amra_isqrt #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (rt_start),
      .value (sq_sum),
      .done  (rt_done),
      .root  (mag)
   );

   amra_window #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (win_ctl),
      .mag   (mag),
      .cfg   (cfg_ff),
      .rsp   (rsp_next)
   );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the accelerometer magnitude range activity detector.
`timescale 1ns / 1ps

module testbench;
   import amra_pkg::*;

   localparam int MAG_BITS    = 17;
   localparam int DRAIN_WAIT  = 2 * FIELD_BITS + 8;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RESET_ROWS  = 2;
   localparam int PHASE_ITEMS = 120;
   localparam int LONG_ITEMS  = 20;

   typedef struct {
      req_type item;
      bit      pinned;
      rsp_type want;
   } row_type;

   typedef struct {
      bit      pinned;
      rsp_type want;
   } pin_type;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   req_type                  req_data    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   accel_magnitude_range_activity_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cfg_type              settings = '{THRESHOLD_RESET, WINDOW_RESET,
                                      DUTY_STILL_RESET, DUTY_MOVING_RESET};
   logic [WLEN_BITS-1:0] win_count   = '0;
   logic [MAG_BITS-1:0]  win_peak    = '0;
   logic [MAG_BITS-1:0]  win_floor   = '1;
   logic [MAG_BITS-1:0]  last_range  = '0;
   logic [MODE_BITS-1:0] motion_mode = MODE_IDLE;

   rsp_type expected_q[$];
   pin_type pin_q[$];
   row_type rows[$];
   int      fail_count     = 0;
   int      accepted_count = 0;
   bit      calm           = 1'b0;
   bit      hold_done      = 1'b0;
   int      amp            = 8;
   int      amp_left       = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("** accel_magnitude_range_activity_top: FAILED **");
      $finish;
   end

   function automatic logic [MAG_BITS-1:0] root_of(input logic [31:0] n);
      logic [MAG_BITS-1:0] r;
      logic [MAG_BITS-1:0] t;
      r = '0;
      for (int b = MAG_BITS - 1; b >= 0; b--) begin
         t = r | (MAG_BITS'(1) << b);
         if (64'(t) * 64'(t) <= 64'(n)) r = t;
      end
      return r;
   endfunction

   function automatic logic [31:0] axis_abs(input logic signed [FIELD_BITS-1:0] v);
      logic signed [FIELD_BITS:0] w;
      w = v;
      if (w < 0) w = -w;
      return 32'(w);
   endfunction

   function automatic rsp_type predict_motion(input req_type s);
      logic [31:0]         ax;
      logic [31:0]         ay;
      logic [31:0]         az;
      logic [MAG_BITS-1:0] mag;
      rsp_type             r;
      r.window_done = 1'b0;
      if (!s.active) begin
         win_count   = '0;
         win_peak    = '0;
         win_floor   = '1;
         last_range  = '0;
         motion_mode = MODE_IDLE;
      end else begin
         ax  = axis_abs(s.accel_x);
         ay  = axis_abs(s.accel_y);
         az  = axis_abs(s.accel_z);
         mag = root_of(ax * ax + ay * ay + az * az);
         if (mag >= win_peak) win_peak = mag;
         if (mag <= win_floor) win_floor = mag;
         win_count = win_count + 1'b1;
         if (win_count >= settings.window_length) begin
            last_range    = win_peak - win_floor;
            win_count     = '0;
            win_peak      = '0;
            win_floor     = '1;
            r.window_done = 1'b1;
            if (last_range < MAG_BITS'(settings.motion_threshold))
               motion_mode = MODE_STILL;
            else if (last_range > MAG_BITS'(settings.motion_threshold) &&
                     motion_mode != MODE_IDLE)
               motion_mode = MODE_MOVING;
         end
      end
      r.range    = last_range[RANGE_BITS-1:0];
      r.activity = motion_mode;
      case (motion_mode)
         MODE_STILL:  r.duty = settings.duty_still;
         MODE_MOVING: r.duty = settings.duty_moving;
         default:     r.duty = '0;
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      pin_type pin;
      rsp_type guess;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result beat with no expected result waiting");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               compare_field("window_done", 32'(want.window_done), 32'(rsp_data.window_done));
               compare_field("range", 32'(want.range), 32'(rsp_data.range));
               compare_field("activity", 32'(want.activity), 32'(rsp_data.activity));
               compare_field("duty", 32'(want.duty), 32'(rsp_data.duty));
            end
         end
         if (req_valid && !req_stall) begin
            pin   = pin_q.pop_front();
            guess = predict_motion(req_data);
            expected_q.push_back(pin.pinned ? pin.want : guess);
            accepted_count++;
         end
      end
   end

   initial begin : receiver
      @(negedge reset);
      forever begin
         if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!hold_done && accepted_count >= 150) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic csr_access(input logic [CSR_IDX_BITS-1:0] idx, input bit wr,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_registers();
      logic [CSR_DATA_BITS-1:0] rd;
      csr_access(CSR_THRESHOLD, 1'b0, '0, rd);
      compare_field("motion_threshold", 32'(settings.motion_threshold), rd);
      csr_access(CSR_WINDOW, 1'b0, '0, rd);
      compare_field("window_length", 32'(settings.window_length), rd);
      csr_access(CSR_DUTY_STILL, 1'b0, '0, rd);
      compare_field("duty_still", 32'(settings.duty_still), rd);
      csr_access(CSR_DUTY_MOVING, 1'b0, '0, rd);
      compare_field("duty_moving", 32'(settings.duty_moving), rd);
   endtask

   // upper bits carry junk; the block keeps only the register width
   task automatic apply_setting(input cfg_type c);
      logic [CSR_DATA_BITS-1:0] rd;
      csr_access(CSR_THRESHOLD, 1'b1, {16'($urandom()), c.motion_threshold}, rd);
      csr_access(CSR_WINDOW, 1'b1, {20'($urandom()), c.window_length}, rd);
      csr_access(CSR_DUTY_STILL, 1'b1, {16'($urandom()), c.duty_still}, rd);
      csr_access(CSR_DUTY_MOVING, 1'b1, {16'($urandom()), c.duty_moving}, rd);
      settings = c;
      check_registers();
   endtask

   // wait for the clock first so the monitor has logged the last accepted beat
   task automatic drain_results();
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic offer_sample(input req_type s, input bit pinned, input rsp_type want);
      pin_q.push_back('{pinned, want});
      req_data  <= s;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic add_row(input logic signed [FIELD_BITS-1:0] x, y, z, input logic act,
                          input bit pinned, input rsp_type want);
      rows.push_back('{'{x, y, z, act}, pinned, want});
   endtask

   function automatic logic signed [FIELD_BITS-1:0] axis_sample(input int a);
      int v;
      if ($urandom_range(0, 15) == 0) return FIELD_BITS'($urandom());
      v = int'($urandom_range(0, 2 * a)) - a;
      return FIELD_BITS'(v);
   endfunction

   initial begin : stimulus
      cfg_type plan[$];
      cfg_type directed_cfg;
      req_type s;
      int      n_items;
      directed_cfg = '{THRESHOLD_RESET, 12'd2, 16'hFFFF, 16'h0001};

      // reset config, window 200
      add_row(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, '{1'b0, 16'd0, MODE_IDLE, 16'd0});
      add_row(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b1,
              '{1'b0, 16'd0, MODE_IDLE, 16'd0});
      // window 2, threshold 10000, duty still FFFF, moving 0001
      add_row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, '{1'b1, 16'd56755, MODE_IDLE, 16'd0});
      add_row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, '{1'b0, 16'd56755, MODE_IDLE, 16'd0});
      add_row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, '{1'b1, 16'd0, MODE_STILL, 16'hFFFF});
      add_row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, '{1'b0, 16'd0, MODE_STILL, 16'hFFFF});
      add_row(16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b0, '0);
      add_row(16'sd10000, 16'sd0, 16'sd0, 1'b1, 1'b0, '0);
      add_row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, '{1'b1, 16'd10000, MODE_MOVING, 16'h0001});
      add_row(16'sd0, -16'sd9999, 16'sd0, 1'b1, 1'b0, '0);
      add_row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, '{1'b1, 16'd9999, MODE_STILL, 16'hFFFF});
      add_row(16'sd3, 16'sd4, 16'sd0, 1'b1, 1'b0, '0);
      add_row(-16'sd1, 16'sd1, -16'sd1, 1'b1, 1'b0, '0);
      add_row(-16'sd32768, 16'sd0, 16'sd0, 1'b1, 1'b0, '0);
      add_row(16'sd0, 16'sd0, 16'sd32767, 1'b1, 1'b0, '0);
      add_row(-16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b1, '{1'b0, 16'd0, MODE_IDLE, 16'd0});
      add_row(16'sd12345, -16'sd23456, 16'sd7, 1'b1, 1'b0, '0);
      add_row(16'sd32767, -16'sd32768, 16'sd21845, 1'b1, 1'b0, '0);
      add_row(-16'sd21846, 16'sd21845, -16'sd1, 1'b1, 1'b0, '0);
      add_row(16'sd100, 16'sd200, 16'sd300, 1'b1, 1'b0, '0);

      // window 0 first: every active sample closes a window
      plan.push_back('{16'd10000, 12'd0, 16'h1234, 16'hFFFF});
      plan.push_back('{16'd3000, 12'd4, 16'hFFFF, 16'h0000});
      plan.push_back('{16'd0, 12'd3, 16'h0000, 16'hFFFF});
      plan.push_back('{16'd65535, 12'd2, 16'hA5A5, 16'h5A5A});
      plan.push_back('{16'($urandom_range(200, 20000)), 12'($urandom_range(1, 8)),
                       16'($urandom()), 16'($urandom())});
      plan.push_back('{16'd1500, 12'd4095, 16'h00FF, 16'hFF00});
      plan.push_back('{16'($urandom_range(200, 20000)), 12'($urandom_range(1, 8)),
                       16'($urandom()), 16'($urandom())});
      plan.push_back('{16'($urandom_range(200, 20000)), 12'($urandom_range(1, 8)),
                       16'($urandom()), 16'($urandom())});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_registers();

      foreach (rows[k]) begin
         if (k == RESET_ROWS) begin
            req_valid <= 1'b0;
            drain_results();
            apply_setting(directed_cfg);
         end
         offer_sample(rows[k].item, rows[k].pinned, rows[k].want);
      end

      foreach (plan[p]) begin
         req_valid <= 1'b0;
         drain_results();
         apply_setting(plan[p]);
         if (p == plan.size() - 1) calm = 1'b1;
         n_items = (plan[p].window_length == 12'd4095) ? LONG_ITEMS : PHASE_ITEMS;
         repeat (n_items) begin
            if (amp_left == 0) begin
               case ($urandom_range(0, 4))
                  0: amp = 8;
                  1: amp = 600;
                  2: amp = 4000;
                  3: amp = 12000;
                  default: amp = 32767;
               endcase
               amp_left = $urandom_range(1, 6);
            end
            amp_left--;
            s.accel_x = axis_sample(amp);
            s.accel_y = axis_sample(amp);
            s.accel_z = axis_sample(amp);
            s.active  = ($urandom_range(0, 29) != 0);
            offer_sample(s, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("** accel_magnitude_range_activity_top: PASSED **");
      else
         $display("** accel_magnitude_range_activity_top: FAILED **");
      $finish;
   end

endmodule

[filelist.f]
hdl/amra_pkg.sv
hdl/amra_sqsum.sv
hdl/amra_isqrt.sv
hdl/amra_window.sv
hdl/accel_magnitude_range_activity_top.sv
tb/sv/testbench.sv
